FILE: rtl/assert_macros.svh
// Assertion macros for the RTL that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a full property on clk_i, off while rst_ni is low.
`define TAC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tac: assertion failed");

// Check a same-cycle implication on clk_i, off while rst_ni is low.
`define TAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tac: implication failed");

`endif

FILE: rtl/tac_pkg.sv
// Types and constants of the triangle angle cotangent block.
`default_nettype none

package tac_pkg;

  // Coordinate width of the input points (signed fixed point).
  localparam int COORD_WIDTH = 32;
  // Width of the sine floor register (unsigned Q1.30) and its reset value.
  localparam int SFW = 31;
  localparam int SF_RESET = 11;
  // Scale of the floor: sine compares against sin_floor / 2^30, squared.
  localparam int SIN_SH = 60;
  // Result width and saturation rails.
  localparam int RES_W = 32;
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FLOOR = 2'd1,
    ST_SAT   = 2'd2,
    ST_DEGEN = 2'd3
  } tac_status_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
  } tac_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] cotangent;
    tac_status_e             status;
  } tac_out_t;

  // Per-item flags that ride along the root search.
  typedef struct packed {
    logic neg;
    logic floored;
    logic degen;
    logic rzero;
  } tac_flags_t;

endpackage

`default_nettype wire

FILE: rtl/triangle_angle_cotangent.sv
// Top level: pipelined cotangent of the angle at apex a of a 3D triangle.
`default_nettype none
`include "assert_macros.svh"

// Takes one triangle per clock: an item is taken at every edge where start is
// high, and busy stays low. Each result appears on res_o for one cycle with done_o
// and cannot be held off. LA, LB and LC are the stages of the three multiplier
// levels (two stages per 32-bit digit of the narrower operand), and the square-root
// style search for the largest t with t^2*R <= Num has two stages per result bit.
// The floor is sampled as an item enters the third multiplier level, so a sin_floor
// write also reaches items already in the pipe: write only with the pipe empty.

module triangle_angle_cotangent
  import tac_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tac_in_t        in_i,
  input  logic           cfg_we_i,
  input  logic [SFW-1:0] cfg_wdata_i,
  output logic           done_o,
  output tac_out_t       res_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int MW    = CW + 1;
  localparam int PAW   = 2 * MW;
  localparam int LUW   = PAW + 2;
  localparam int QW    = 2 * LUW;
  localparam int CQW   = QW + 2;
  localparam int F2W   = 2 * SFW;
  localparam int RHW   = QW + F2W;
  localparam int LA    = 2 * ((MW + 31) / 32);
  localparam int LB    = 2 * ((LUW + 31) / 32);
  localparam int LC    = 2 * ((F2W + 31) / 32);
  localparam int LSW   = CQW + SIN_SH;
  localparam int CMPW  = (LSW > RHW) ? LSW : RHW;
  localparam int RW    = (RHW > CQW) ? RHW : CQW;
  localparam int NSH   = 2 * FRAC_BITS;
  localparam int NW    = QW + SIN_SH + NSH;
  localparam int TW    = RES_W;
  localparam int QQW   = RW + TW;
  localparam int SW0   = (NW > RW + 2 * TW) ? NW : RW + 2 * TW;
  localparam int SW    = SW0 + 1;
  localparam int SDW   = CQW + QW + 2;
  localparam int LAT   = 6 + LA + LB + LC + 2 * TW;

  // Operand pairs of the first multiplier level: u is 0..2, v is 3..5
  localparam int PA_I [15] = '{0, 1, 2, 3, 4, 5, 0, 1, 2, 1, 2, 2, 0, 0, 1};
  localparam int PB_I [15] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 5, 4, 3, 5, 4, 3};

  assign busy = 1'b0;

  // Hold the squared sine floor
  logic [F2W-1:0] f2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_q <= F2W'(SF_RESET * SF_RESET);
    end else if (cfg_we_i) begin
      f2_q <= {{SFW{1'b0}}, cfg_wdata_i} * {{SFW{1'b0}}, cfg_wdata_i};
    end
  end

  // Capture the input transfer
  logic    v0_q;
  tac_in_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= in_i;
    end
  end

  // Form edge vectors u = b - a, v = c - a as sign and magnitude
  logic signed [CW-1:0] pa [3];
  logic signed [CW-1:0] pb [6];
  logic signed [CW:0]   dif [6];
  logic [MW-1:0]        dm_d [6];
  logic [MW-1:0]        dm_q [6];
  logic [5:0]           ds_q;
  logic                 v1_q;

  assign pa[0] = in_q.a_x;
  assign pa[1] = in_q.a_y;
  assign pa[2] = in_q.a_z;
  assign pb[0] = in_q.b_x;
  assign pb[1] = in_q.b_y;
  assign pb[2] = in_q.b_z;
  assign pb[3] = in_q.c_x;
  assign pb[4] = in_q.c_y;
  assign pb[5] = in_q.c_z;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      dif[i]  = {pb[i][CW-1], pb[i]} - {pa[i%3][CW-1], pa[i%3]};
      dm_d[i] = dif[i][CW] ? MW'(-dif[i]) : MW'(dif[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 6; i++) begin
      dm_q[i] <= dm_d[i];
      ds_q[i] <= dif[i][CW];
    end
  end

  // First multiplier level: squares, dot terms and cross terms
  logic [14:0]        va_v;
  logic [PAW-1:0]     pm_a [15];
  logic [14:0]        ps_a;
  logic signed [PAW:0] sa [15];

  for (genvar g = 0; g < 15; g++) begin : g_mul_a
    tac_mul #(.WA(MW), .WB(MW), .WS(1)) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v1_q),
      .a_i     (dm_q[PA_I[g]]),
      .b_i     (dm_q[PB_I[g]]),
      .side_i  (ds_q[PA_I[g]] ^ ds_q[PB_I[g]]),
      .valid_o (va_v[g]),
      .p_o     (pm_a[g]),
      .side_o  (ps_a[g])
    );
    assign sa[g] = ps_a[g] ? -$signed({1'b0, pm_a[g]}) : $signed({1'b0, pm_a[g]});
  end

  // Sum squared lengths, dot product and cross components
  logic signed [PAW+2:0] p_s;
  logic signed [PAW+2:0] c_s [3];
  logic [LUW-1:0]        lu_d, lv_d, pm_d;
  logic [LUW-1:0]        cm_d [3];
  logic [LUW-1:0]        lu_q, lv_q, pm_q;
  logic [LUW-1:0]        cm_q [3];
  logic                  pn_q, dg_q, v2_q;

  always_comb begin
    lu_d   = LUW'(pm_a[0]) + LUW'(pm_a[1]) + LUW'(pm_a[2]);
    lv_d   = LUW'(pm_a[3]) + LUW'(pm_a[4]) + LUW'(pm_a[5]);
    p_s    = (PAW+3)'(sa[6]) + (PAW+3)'(sa[7]) + (PAW+3)'(sa[8]);
    c_s[0] = (PAW+3)'(sa[9]) - (PAW+3)'(sa[10]);
    c_s[1] = (PAW+3)'(sa[11]) - (PAW+3)'(sa[12]);
    c_s[2] = (PAW+3)'(sa[13]) - (PAW+3)'(sa[14]);
    pm_d   = p_s[PAW+2] ? LUW'(-p_s) : LUW'(p_s);
    for (int i = 0; i < 3; i++) begin
      cm_d[i] = c_s[i][PAW+2] ? LUW'(-c_s[i]) : LUW'(c_s[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= va_v[0];
    end
  end
  always_ff @(posedge clk_i) begin
    lu_q <= lu_d;
    lv_q <= lv_d;
    pm_q <= pm_d;
    pn_q <= p_s[PAW+2];
    dg_q <= (lu_d == '0) || (lv_d == '0);
    for (int i = 0; i < 3; i++) begin
      cm_q[i] <= cm_d[i];
    end
  end

  // Second multiplier level: cross squares, dot square, length product
  logic [QW-1:0] cs_b [3];
  logic [QW-1:0] pp_b, luv_b;
  logic [1:0]    sd_b;
  logic          vb;

  for (genvar g = 0; g < 3; g++) begin : g_mul_b
    tac_mul #(.WA(LUW), .WB(LUW), .WS(1)) u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v2_q),
      .a_i     (cm_q[g]),
      .b_i     (cm_q[g]),
      .side_i  (1'b0),
      .valid_o (),
      .p_o     (cs_b[g]),
      .side_o  ()
    );
  end

  tac_mul #(.WA(LUW), .WB(LUW), .WS(2)) u_mul_pp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .a_i     (pm_q),
    .b_i     (pm_q),
    .side_i  ({pn_q, dg_q}),
    .valid_o (vb),
    .p_o     (pp_b),
    .side_o  (sd_b)
  );

  tac_mul #(.WA(LUW), .WB(LUW), .WS(1)) u_mul_luv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .a_i     (lu_q),
    .b_i     (lv_q),
    .side_i  (1'b0),
    .valid_o (),
    .p_o     (luv_b),
    .side_o  ()
  );

  // Sum the squared cross product
  logic [CQW-1:0] cq_q;
  logic [QW-1:0]  pp_q, luv_q;
  logic           pn3_q, dg3_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= vb;
    end
  end
  always_ff @(posedge clk_i) begin
    cq_q  <= CQW'(cs_b[0]) + CQW'(cs_b[1]) + CQW'(cs_b[2]);
    pp_q  <= pp_b;
    luv_q <= luv_b;
    pn3_q <= sd_b[1];
    dg3_q <= sd_b[0];
  end

  // Third multiplier level: floor^2 * |u|^2 * |v|^2
  logic [RHW-1:0] rhs_c;
  logic [SDW-1:0] sd_c;
  logic           vc;

  tac_mul #(.WA(QW), .WB(F2W), .WS(SDW)) u_mul_rhs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .a_i     (luv_q),
    .b_i     (f2_q),
    .side_i  ({cq_q, pp_q, pn3_q, dg3_q}),
    .valid_o (vc),
    .p_o     (rhs_c),
    .side_o  (sd_c)
  );

  // Decide the floor and set up divisor and numerator
  logic [CQW-1:0] cq_c;
  logic [QW-1:0]  pp_c;
  logic           fl_c;
  logic [RW-1:0]  r_c;
  logic [NW-1:0]  num_c;
  logic [RW-1:0]  r4_q;
  logic [NW-1:0]  num4_q;
  tac_flags_t     f4_q;
  logic           v4_q;

  always_comb begin
    cq_c  = sd_c[SDW-1 -: CQW];
    pp_c  = sd_c[QW+1:2];
    fl_c  = (CMPW'(cq_c) << SIN_SH) <= CMPW'(rhs_c);
    r_c   = fl_c ? RW'(rhs_c) : RW'(cq_c);
    num_c = fl_c ? (NW'(pp_c) << (SIN_SH + NSH)) : (NW'(pp_c) << NSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= vc;
    end
  end
  always_ff @(posedge clk_i) begin
    r4_q          <= r_c;
    num4_q        <= num_c;
    f4_q.neg      <= sd_c[1];
    f4_q.degen    <= sd_c[0];
    f4_q.floored  <= fl_c;
    f4_q.rzero    <= (r_c == '0);
  end

  // Search t bit by bit: D = Num - t^2*R, Q = t*R
  logic [TW:0]     vr;
  logic [NW-1:0]   dr [TW+1];
  logic [QQW-1:0]  qr [TW+1];
  logic [TW-1:0]   tr [TW+1];
  logic [RW-1:0]   rr [TW+1];
  tac_flags_t      fr [TW+1];

  assign vr[0] = v4_q;
  assign dr[0] = num4_q;
  assign qr[0] = '0;
  assign tr[0] = '0;
  assign rr[0] = r4_q;
  assign fr[0] = f4_q;

  for (genvar j = 0; j < TW; j++) begin : g_bit
    localparam int K = TW - 1 - j;
    logic           va_q, vb_q;
    logic [SW-1:0]  ta_q;
    logic [NW-1:0]  da_q, db_q;
    logic [QQW-1:0] qa_q, qb_q;
    logic [TW-1:0]  tta_q, ttb_q;
    logic [RW-1:0]  ra_q, rb_q;
    tac_flags_t     fa_q, fb_q;
    logic [SW:0]    df;
    logic           take;

    assign df   = {1'b0, SW'(da_q)} - {1'b0, ta_q};
    assign take = !df[SW];

    // Advance valid bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        va_q <= 1'b0;
        vb_q <= 1'b0;
      end else begin
        va_q <= vr[j];
        vb_q <= va_q;
      end
    end

    // Form the increment, then try it against the remainder
    always_ff @(posedge clk_i) begin
      ta_q  <= (SW'(qr[j]) << (K + 1)) + (SW'(rr[j]) << (2 * K));
      da_q  <= dr[j];
      qa_q  <= qr[j];
      tta_q <= tr[j];
      ra_q  <= rr[j];
      fa_q  <= fr[j];
      db_q  <= take ? df[NW-1:0] : da_q;
      qb_q  <= take ? qa_q + (QQW'(ra_q) << K) : qa_q;
      ttb_q <= tta_q | (TW'(take) << K);
      rb_q  <= ra_q;
      fb_q  <= fa_q;
    end

    assign vr[j+1] = vb_q;
    assign dr[j+1] = db_q;
    assign qr[j+1] = qb_q;
    assign tr[j+1] = ttb_q;
    assign rr[j+1] = rb_q;
    assign fr[j+1] = fb_q;
  end

  // Apply sign, saturation and status
  logic [TW-1:0] tf;
  tac_out_t      res_d, res_q;
  logic          done_q;

  always_comb begin
    tf = fr[TW].rzero ? '1 : tr[TW];
    if (fr[TW].degen) begin
      res_d.cotangent = '0;
      res_d.status    = ST_DEGEN;
    end else if (!fr[TW].neg && (tf > RES_MAX)) begin
      res_d.cotangent = RES_MAX;
      res_d.status    = ST_SAT;
    end else if (fr[TW].neg && (tf > RES_MIN)) begin
      res_d.cotangent = RES_MIN;
      res_d.status    = ST_SAT;
    end else begin
      res_d.cotangent = fr[TW].neg ? -tf : tf;
      res_d.status    = fr[TW].floored ? ST_FLOOR : ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vr[TW];
    end
  end
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Checks
  logic on_rail;
  assign on_rail = (res_o.cotangent == RES_MAX) || (res_o.cotangent == RES_MIN);

  `TAC_ASSERT_IMP(a_deg_zero, done_o && res_o.status == ST_DEGEN, res_o.cotangent == '0)
  `TAC_ASSERT_IMP(a_sat_rail, done_o && res_o.status == ST_SAT, on_rail)
  `TAC_ASSERT_IMP(a_lane_sync, va_v != '0, va_v == '1)
  `TAC_ASSERT(a_latency, start && !busy |-> ##LAT done_o)

endmodule

`default_nettype wire

FILE: rtl/tac_mul.sv
// Pipelined unsigned multiplier: one 32-bit digit of b per stage pair, 32x32 lanes.
`default_nettype none

module tac_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int WS = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WA-1:0]    a_i,
  input  logic [WB-1:0]    b_i,
  input  logic [WS-1:0]    side_i,
  output logic             valid_o,
  output logic [WA+WB-1:0] p_o,
  output logic [WS-1:0]    side_o
);

  localparam int NA = (WA + 31) / 32;
  localparam int NB = (WB + 31) / 32;
  localparam int NE = (NA + 1) / 2;
  localparam int LW = NE * 64;
  localparam int BW = NB * 32;
  localparam int PW = LW + BW;

  logic [NB:0]   vin;
  logic [LW-1:0] ain [NB+1];
  logic [BW-1:0] bin [NB+1];
  logic [WS-1:0] sdn [NB+1];
  logic [PW-1:0] acc [NB+1];

  assign vin[0] = valid_i;
  assign ain[0] = LW'(a_i);
  assign bin[0] = BW'(b_i);
  assign sdn[0] = side_i;
  assign acc[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_digit
    logic [LW-1:0] e_d, o_d, e_q, o_q;
    logic          vm_q, vs_q;
    logic [LW-1:0] am_q, as_q;
    logic [BW-1:0] bm_q, bs_q;
    logic [WS-1:0] sm_q, ss_q;
    logic [PW-1:0] accm_q, accs_q;

    // Form even and odd lane products of a with digit k
    always_comb begin
      e_d = '0;
      o_d = '0;
      for (int j = 0; j < NE; j++) begin
        e_d[64*j +: 64] = {32'b0, ain[k][64*j +: 32]} * {32'b0, bin[k][32*k +: 32]};
        o_d[64*j +: 64] = {32'b0, ain[k][64*j+32 +: 32]} * {32'b0, bin[k][32*k +: 32]};
      end
    end

    // Advance valid bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q <= 1'b0;
        vs_q <= 1'b0;
      end else begin
        vm_q <= vin[k];
        vs_q <= vm_q;
      end
    end

    // Register lane products, then fold them into the accumulator
    always_ff @(posedge clk_i) begin
      e_q    <= e_d;
      o_q    <= o_d;
      am_q   <= ain[k];
      bm_q   <= bin[k];
      sm_q   <= sdn[k];
      accm_q <= acc[k];
      accs_q <= accm_q + ((PW'(e_q) + (PW'(o_q) << 32)) << (32 * k));
      as_q   <= am_q;
      bs_q   <= bm_q;
      ss_q   <= sm_q;
    end

    assign vin[k+1] = vs_q;
    assign ain[k+1] = as_q;
    assign bin[k+1] = bs_q;
    assign sdn[k+1] = ss_q;
    assign acc[k+1] = accs_q;
  end

  assign valid_o = vin[NB];
  assign p_o     = acc[NB][WA+WB-1:0];
  assign side_o  = sdn[NB];

endmodule

`default_nettype wire
